### hw/rtl/emb_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the level-to-value table of the edge motion blur block
// no dependencies; used by every module under hw/rtl except emb_level_ram

package emb_pkg;

    // frame limits and blur scale
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int TOP_LEVEL  = 31;
    localparam int MIN_SIZE   = 3;
    localparam int FULL_SCALE = 255;

    // level filter: subtract a bias once the neighbor sum exceeds it, then divide by four
    localparam int SUM_BIAS  = 3;
    localparam int SUM_SHIFT = 2;

    // widths fixed by the stream and register fields
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 10;
    localparam int BLUR_W     = 5;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int OUT_DATA_W = 32;

    // widths derived from the frame limits
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_CNT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int LEVEL_W    = $clog2(TOP_LEVEL + 1);
    localparam int SUM_W      = LEVEL_W + 2;
    localparam int LUT_N      = 2**LEVEL_W;

    // one memory per row parity: {store, row without its lsb, column}
    localparam int RAM_ADDR_W = 1 + (ROW_W - 1) + COL_W;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_RED       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_GREEN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_BLUE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 3'd5;

    localparam logic [SIZE_W-1:0] RESET_FRAME_WIDTH    = 10'd320;
    localparam logic [SIZE_W-1:0] RESET_FRAME_HEIGHT   = 10'd240;
    localparam logic [PIX_W-1:0]  RESET_TINT           = 8'd255;
    localparam logic [PIX_W-1:0]  RESET_EDGE_THRESHOLD = 8'd64;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [PIX_W-1:0]  tint_red;
        logic [PIX_W-1:0]  tint_green;
        logic [PIX_W-1:0]  tint_blue;
        logic [PIX_W-1:0]  edge_threshold;
    } cfg_t;

    // per-pixel info carried from the scan stage into the level stage
    typedef struct packed {
        logic                  interior;
        logic                  frame_end;
        logic                  full;
        logic                  bank;
        logic [RAM_ADDR_W-1:0] wr_addr;
    } pix_t;

    // scan stage output: pixel info plus neighbor read addresses [bank][port]
    typedef struct packed {
        pix_t                            pix;
        logic [1:0][1:0][RAM_ADDR_W-1:0] rd_addr;
    } scan_t;

    typedef struct packed {
        logic                  en;
        logic                  bank;
        logic [RAM_ADDR_W-1:0] addr;
        logic [LEVEL_W-1:0]    data;
    } wr_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               interior;
        logic               frame_end;
    } lvl_t;

    typedef logic [PIX_W-1:0] shade_lut_t [LUT_N];

    // level -> gray value, worked out at elaboration
    function automatic shade_lut_t build_shade_lut();
        shade_lut_t lut;
        for (int i = 0; i < LUT_N; i++) begin
            lut[i] = PIX_W'((FULL_SCALE * i) / TOP_LEVEL);
        end
        return lut;
    endfunction

    localparam shade_lut_t SHADE_LUT = build_shade_lut();

endpackage

### hw/rtl/emb_level_ram.sv
`timescale 1ns / 1ps
// blur level memory: one write port, two registered read ports
// generic; no package dependency

module emb_level_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hw/rtl/emb_scan.sv
`timescale 1ns / 1ps
// raster scan stage: column/row counters, store select, border test, neighbor addresses
// depends on emb_pkg

module emb_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  emb_pkg::cfg_t             cfg,
    input  logic [emb_pkg::PIX_W-1:0] edge_strength,
    input  logic                      accept,
    output emb_pkg::scan_t            scan
);

    logic [emb_pkg::COL_W-1:0]     col_reg;
    logic [emb_pkg::COL_W-1:0]     col_next;
    logic [emb_pkg::ROW_W-1:0]     row_reg;
    logic [emb_pkg::ROW_W-1:0]     row_next;
    logic                          sel_reg;
    logic                          sel_next;
    logic [emb_pkg::COL_CNT_W-1:0] width_eff;
    logic [emb_pkg::ROW_CNT_W-1:0] height_eff;
    logic [emb_pkg::COL_CNT_W-1:0] col_inc;
    logic [emb_pkg::ROW_CNT_W-1:0] row_inc;
    logic                          line_end;
    logic                          last_row;
    logic [emb_pkg::COL_W-1:0]     col_left;
    logic [emb_pkg::COL_W-1:0]     col_right;
    logic [emb_pkg::ROW_W-1:0]     row_up;
    logic [emb_pkg::ROW_W-1:0]     row_down;
    logic                          same_bank;

    // clamp frame size
    always_comb
    begin
        if (int'(cfg.frame_width) < emb_pkg::MIN_SIZE)
            width_eff = emb_pkg::COL_CNT_W'(emb_pkg::MIN_SIZE);
        else if (int'(cfg.frame_width) > emb_pkg::MAX_WIDTH)
            width_eff = emb_pkg::COL_CNT_W'(emb_pkg::MAX_WIDTH);
        else
            width_eff = emb_pkg::COL_CNT_W'(cfg.frame_width);

        if (int'(cfg.frame_height) < emb_pkg::MIN_SIZE)
            height_eff = emb_pkg::ROW_CNT_W'(emb_pkg::MIN_SIZE);
        else if (int'(cfg.frame_height) > emb_pkg::MAX_HEIGHT)
            height_eff = emb_pkg::ROW_CNT_W'(emb_pkg::MAX_HEIGHT);
        else
            height_eff = emb_pkg::ROW_CNT_W'(cfg.frame_height);
    end

    assign col_inc  = emb_pkg::COL_CNT_W'(col_reg) + emb_pkg::COL_CNT_W'(1);
    assign row_inc  = emb_pkg::ROW_CNT_W'(row_reg) + emb_pkg::ROW_CNT_W'(1);
    assign line_end = (col_inc >= width_eff);
    assign last_row = (row_inc >= height_eff);

    assign col_left  = col_reg - emb_pkg::COL_W'(1);
    assign col_right = col_reg + emb_pkg::COL_W'(1);
    assign row_up    = row_reg - emb_pkg::ROW_W'(1);
    assign row_down  = row_reg + emb_pkg::ROW_W'(1);
    assign same_bank = row_reg[0];

    always_comb
    begin
        scan = '0;
        scan.pix.interior  = (col_reg != '0) && !line_end && (row_reg != '0) && !last_row;
        scan.pix.frame_end = line_end && last_row;
        scan.pix.full      = (edge_strength > cfg.edge_threshold);
        scan.pix.bank      = same_bank;
        scan.pix.wr_addr   = {~sel_reg, row_reg[emb_pkg::ROW_W-1:1], col_reg};
        // left/right live in this row's bank, up/down in the other one
        scan.rd_addr[same_bank][0]  = {sel_reg, row_reg[emb_pkg::ROW_W-1:1], col_left};
        scan.rd_addr[same_bank][1]  = {sel_reg, row_reg[emb_pkg::ROW_W-1:1], col_right};
        scan.rd_addr[~same_bank][0] = {sel_reg, row_up[emb_pkg::ROW_W-1:1], col_reg};
        scan.rd_addr[~same_bank][1] = {sel_reg, row_down[emb_pkg::ROW_W-1:1], col_reg};
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        sel_next = sel_reg;
        if (accept)
        begin
            if (line_end)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    sel_next = ~sel_reg;
                end
                else
                begin
                    row_next = row_reg + emb_pkg::ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + emb_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            sel_reg <= sel_next;
        end
    end

endmodule

### hw/rtl/emb_level.sv
`timescale 1ns / 1ps
// level stage: holds pixel info beside the memory read data, forms the new blur level
// depends on emb_pkg

module emb_level (
    input  logic                                    clk,
    input  logic                                    load,
    input  emb_pkg::pix_t                           pix_in,
    input  logic [1:0][1:0][emb_pkg::LEVEL_W-1:0]   rd_data,
    output emb_pkg::wr_t                            wr,
    output emb_pkg::lvl_t                           lvl
);

    emb_pkg::pix_t               pix_reg;
    logic [emb_pkg::SUM_W-1:0]   sum;
    logic [emb_pkg::SUM_W-1:0]   sum_adj;
    logic [emb_pkg::LEVEL_W-1:0] level_avg;
    logic [emb_pkg::LEVEL_W-1:0] level;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix_in;
        end
    end

    // neighbor order does not matter for the sum
    assign sum = emb_pkg::SUM_W'(rd_data[0][0]) + emb_pkg::SUM_W'(rd_data[0][1])
               + emb_pkg::SUM_W'(rd_data[1][0]) + emb_pkg::SUM_W'(rd_data[1][1]);

    assign sum_adj   = (sum > emb_pkg::SUM_W'(emb_pkg::SUM_BIAS))
                     ? sum - emb_pkg::SUM_W'(emb_pkg::SUM_BIAS) : sum;
    assign level_avg = emb_pkg::LEVEL_W'(sum_adj >> emb_pkg::SUM_SHIFT);

    always_comb
    begin
        if (!pix_reg.interior)
            level = '0;
        else if (pix_reg.full)
            level = emb_pkg::LEVEL_W'(emb_pkg::TOP_LEVEL);
        else
            level = level_avg;
    end

    assign wr.en   = pix_reg.interior;
    assign wr.bank = pix_reg.bank;
    assign wr.addr = pix_reg.wr_addr;
    assign wr.data = level;

    assign lvl.level     = level;
    assign lvl.interior  = pix_reg.interior;
    assign lvl.frame_end = pix_reg.frame_end;

endmodule

### hw/rtl/emb_shade.sv
`timescale 1ns / 1ps
// colour stages: level to gray value by table, tint multiply, output register
// depends on emb_pkg

module emb_shade (
    input  logic                        clk,
    input  logic                        load2,
    input  logic                        load3,
    input  logic                        load4,
    input  emb_pkg::cfg_t               cfg,
    input  emb_pkg::lvl_t               lvl_in,
    output logic [emb_pkg::PIX_W-1:0]   red,
    output logic [emb_pkg::PIX_W-1:0]   green,
    output logic [emb_pkg::PIX_W-1:0]   blue,
    output logic [emb_pkg::LEVEL_W-1:0] level,
    output logic                        written,
    output logic                        frame_end
);

    emb_pkg::lvl_t               s2_reg;
    emb_pkg::lvl_t               s3_reg;
    logic [emb_pkg::PIX_W-1:0]   value_reg;
    logic [emb_pkg::PROD_W-1:0]  prod_red;
    logic [emb_pkg::PROD_W-1:0]  prod_green;
    logic [emb_pkg::PROD_W-1:0]  prod_blue;
    logic [emb_pkg::PIX_W-1:0]   red_reg;
    logic [emb_pkg::PIX_W-1:0]   green_reg;
    logic [emb_pkg::PIX_W-1:0]   blue_reg;
    logic [emb_pkg::LEVEL_W-1:0] level_reg;
    logic                        written_reg;
    logic                        frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_reg <= lvl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_reg    <= s2_reg;
            value_reg <= emb_pkg::SHADE_LUT[s2_reg.level];
        end
    end

    assign prod_red   = emb_pkg::PROD_W'(value_reg) * emb_pkg::PROD_W'(cfg.tint_red);
    assign prod_green = emb_pkg::PROD_W'(value_reg) * emb_pkg::PROD_W'(cfg.tint_green);
    assign prod_blue  = emb_pkg::PROD_W'(value_reg) * emb_pkg::PROD_W'(cfg.tint_blue);

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            red_reg       <= prod_red[emb_pkg::PROD_W-1:emb_pkg::PIX_W];
            green_reg     <= prod_green[emb_pkg::PROD_W-1:emb_pkg::PIX_W];
            blue_reg      <= prod_blue[emb_pkg::PROD_W-1:emb_pkg::PIX_W];
            level_reg     <= s3_reg.level;
            written_reg   <= s3_reg.interior;
            frame_end_reg <= s3_reg.frame_end;
        end
    end

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign level     = level_reg;
    assign written   = written_reg;
    assign frame_end = frame_end_reg;

endmodule

### hw/rtl/edge_motion_blur_frame.sv
`timescale 1ns / 1ps
// top level of the edge motion blur block: config registers, pipeline control, level memories
// depends on emb_pkg, emb_scan, emb_level, emb_shade, emb_level_ram

// Takes one edge-strength byte per beat in raster order and returns one tinted
// pixel per beat, one pixel per clock sustained while m_tready stays high. The
// pipeline has four register stages (memory read, blur level, gray value, tint
// multiply) with a valid bit each; a stage refills as soon as it empties, so a
// waiting output beat does not block new input beats while any stage is free.
// The rate comes from the level memories: levels are kept in two memories split
// by row parity, each holding both frame stores, so the left and right neighbors
// come from one memory and the up and down neighbors from the other, two reads
// per memory per clock, while the new level goes into the other store. After
// reset the memories are cleared one entry per clock, all 2**RAM_ADDR_W entries
// (262144 at the default 512x512 limit); s_tready stays low during that pass,
// configuration writes are taken throughout. The user must write registers only
// while no beat is in flight; the block does not enforce it. frame_end is sent as m_tlast.

module edge_motion_blur_frame (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [emb_pkg::PIX_W-1:0]           s_tdata,   // [7:0] edge_strength
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [emb_pkg::OUT_DATA_W-1:0]      m_tdata,   // [7:0] out_red, [15:8] out_green,
                                                           // [23:16] out_blue, [28:24] blur_level
    output logic                                m_tuser,   // [0] pixel_written
    output logic                                m_tlast,   // frame_end
    // configuration writes
    input  logic                                cfg_we,
    input  logic [emb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [emb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    emb_pkg::cfg_t                         cfg_reg;
    emb_pkg::cfg_t                         cfg_next;

    // stage valid bits: 1 memory read, 2 level, 3 gray value, 4 output
    logic                                  valid1_reg;
    logic                                  valid1_next;
    logic                                  valid2_reg;
    logic                                  valid2_next;
    logic                                  valid3_reg;
    logic                                  valid3_next;
    logic                                  valid4_reg;
    logic                                  valid4_next;
    logic                                  load1;
    logic                                  load2;
    logic                                  load3;
    logic                                  load4;
    logic                                  accept;

    // memory clearing pass after reset
    logic                                  clearing_reg;
    logic                                  clearing_next;
    logic [emb_pkg::RAM_ADDR_W-1:0]        clear_addr_reg;
    logic [emb_pkg::RAM_ADDR_W-1:0]        clear_addr_next;

    emb_pkg::scan_t                        scan;
    emb_pkg::wr_t                          wr;
    emb_pkg::lvl_t                         lvl;
    logic [1:0][1:0][emb_pkg::LEVEL_W-1:0] rd_data;
    logic [1:0]                            ram_we;
    logic                                  pipe_we;
    logic [emb_pkg::RAM_ADDR_W-1:0]        ram_waddr;
    logic [emb_pkg::LEVEL_W-1:0]           ram_wdata;

    logic [emb_pkg::PIX_W-1:0]             out_red;
    logic [emb_pkg::PIX_W-1:0]             out_green;
    logic [emb_pkg::PIX_W-1:0]             out_blue;
    logic [emb_pkg::LEVEL_W-1:0]           out_level;
    logic                                  out_written;
    logic                                  out_frame_end;

    // ---------------------------------------------------------------------
    // configuration registers, unknown indexes are dropped
    // ---------------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                emb_pkg::REG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data;
                emb_pkg::REG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data;
                emb_pkg::REG_TINT_RED:       cfg_next.tint_red       = cfg_data[emb_pkg::PIX_W-1:0];
                emb_pkg::REG_TINT_GREEN:     cfg_next.tint_green     = cfg_data[emb_pkg::PIX_W-1:0];
                emb_pkg::REG_TINT_BLUE:      cfg_next.tint_blue      = cfg_data[emb_pkg::PIX_W-1:0];
                emb_pkg::REG_EDGE_THRESHOLD: cfg_next.edge_threshold = cfg_data[emb_pkg::PIX_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= emb_pkg::RESET_FRAME_WIDTH;
            cfg_reg.frame_height   <= emb_pkg::RESET_FRAME_HEIGHT;
            cfg_reg.tint_red       <= emb_pkg::RESET_TINT;
            cfg_reg.tint_green     <= emb_pkg::RESET_TINT;
            cfg_reg.tint_blue      <= emb_pkg::RESET_TINT;
            cfg_reg.edge_threshold <= emb_pkg::RESET_EDGE_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------------
    assign load4  = !valid4_reg || m_tready;
    assign load3  = !valid3_reg || load4;
    assign load2  = !valid2_reg || load3;
    assign load1  = !valid1_reg || load2;

    assign s_tready = load1 && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    assign valid1_next = load1 ? accept     : valid1_reg;
    assign valid2_next = load2 ? valid1_reg : valid2_reg;
    assign valid3_next = load3 ? valid2_reg : valid3_reg;
    assign valid4_next = load4 ? valid3_reg : valid4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
            valid4_reg <= valid4_next;
        end
    end

    // ---------------------------------------------------------------------
    // clearing pass: zero every entry of both memories, one address per clock
    // ---------------------------------------------------------------------
    always_comb
    begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clearing_reg)
        begin
            clear_addr_next = clear_addr_reg + emb_pkg::RAM_ADDR_W'(1);
            if (clear_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 0: raster scan and neighbor addresses
    // ---------------------------------------------------------------------
    emb_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .edge_strength (s_tdata),
        .accept        (accept),
        .scan          (scan)
    );

    // ---------------------------------------------------------------------
    // level memories, bank = row parity; the new level is written as the
    // pixel leaves the level stage, into the store not being read this frame
    // ---------------------------------------------------------------------
    assign pipe_we   = valid1_reg && load2 && wr.en;
    assign ram_waddr = clearing_reg ? clear_addr_reg : wr.addr;
    assign ram_wdata = clearing_reg ? '0 : wr.data;

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        assign ram_we[b] = clearing_reg || (pipe_we && (wr.bank == 1'(b)));

        emb_level_ram #(
            .ADDR_W (emb_pkg::RAM_ADDR_W),
            .DATA_W (emb_pkg::LEVEL_W)
        ) u_ram (
            .clk     (clk),
            .we      (ram_we[b]),
            .waddr   (ram_waddr),
            .wdata   (ram_wdata),
            .re      (load1),
            .raddr_a (scan.rd_addr[b][0]),
            .raddr_b (scan.rd_addr[b][1]),
            .rdata_a (rd_data[b][0]),
            .rdata_b (rd_data[b][1])
        );
    end

    // ---------------------------------------------------------------------
    // stage 1: blur level
    // ---------------------------------------------------------------------
    emb_level u_level (
        .clk     (clk),
        .load    (load1),
        .pix_in  (scan.pix),
        .rd_data (rd_data),
        .wr      (wr),
        .lvl     (lvl)
    );

    // ---------------------------------------------------------------------
    // stages 2 to 4: gray value, tint, output register
    // ---------------------------------------------------------------------
    emb_shade u_shade (
        .clk       (clk),
        .load2     (load2),
        .load3     (load3),
        .load4     (load4),
        .cfg       (cfg_reg),
        .lvl_in    (lvl),
        .red       (out_red),
        .green     (out_green),
        .blue      (out_blue),
        .level     (out_level),
        .written   (out_written),
        .frame_end (out_frame_end)
    );

    assign m_tvalid = valid4_reg;
    assign m_tdata  = {3'b000, emb_pkg::BLUR_W'(out_level), out_blue, out_green, out_red};
    assign m_tuser  = out_written;
    assign m_tlast  = out_frame_end;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------

    // nothing may be in flight while the memories are being cleared
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !(valid1_reg || valid2_reg || valid3_reg || valid4_reg))
        else $error("pixel in pipeline during memory clearing");

    // a border pixel carries no colour and no level
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("border pixel with nonzero payload");

    // the last pixel of a frame lies on the bottom row, so it is never written
    a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("frame end beat marked as written");

endmodule
